// ===== design/bds_pkg.sv =====
// Package for the box difference splitter: piece kind codes and the layout
// of one queued job. No dependencies.
package bds_pkg;

    // Kind of a result piece; the value is also its bit in the piece mask.
    typedef enum logic [2:0] {
        KIND_WHOLE   = 3'd0,
        KIND_BELOW_Z = 3'd1,
        KIND_ABOVE_Z = 3'd2,
        KIND_X_MIN   = 3'd3,
        KIND_X_MAX   = 3'd4,
        KIND_Y_MIN   = 3'd5,
        KIND_Y_MAX   = 3'd6
    } t_piece_kind;

    // Number of piece kinds, and so the width of the piece mask.
    localparam int NUM_KINDS = 7;

    // Coordinates carried by one queued job, by slot.
    localparam int J_AX0 = 0;
    localparam int J_AY0 = 1;
    localparam int J_AZ0 = 2;
    localparam int J_AX1 = 3;
    localparam int J_AY1 = 4;
    localparam int J_AZ1 = 5;
    localparam int J_BX0 = 6;
    localparam int J_BY0 = 7;
    localparam int J_BZ0 = 8;
    localparam int J_BX1 = 9;
    localparam int J_BY1 = 10;
    localparam int J_BZ1 = 11;
    localparam int J_MZ0 = 12;
    localparam int J_MZ1 = 13;
    localparam int J_MX0 = 14;
    localparam int J_MX1 = 15;
    localparam int NUM_COORDS = 16;

    // Depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== design/bds_channels.sv =====
// Valid/ready channel interfaces for the box difference splitter: the input
// box pair and the output piece. Depends on nothing but its parameter.
interface bds_in_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_min_x;
    logic signed [COORD_WIDTH-1:0] a_min_y;
    logic signed [COORD_WIDTH-1:0] a_min_z;
    logic signed [COORD_WIDTH-1:0] a_max_x;
    logic signed [COORD_WIDTH-1:0] a_max_y;
    logic signed [COORD_WIDTH-1:0] a_max_z;
    logic signed [COORD_WIDTH-1:0] b_min_x;
    logic signed [COORD_WIDTH-1:0] b_min_y;
    logic signed [COORD_WIDTH-1:0] b_min_z;
    logic signed [COORD_WIDTH-1:0] b_max_x;
    logic signed [COORD_WIDTH-1:0] b_max_y;
    logic signed [COORD_WIDTH-1:0] b_max_z;

    modport source (
        output valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
               b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z,
        input  ready
    );
    modport sink (
        input  valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
               b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z,
        output ready
    );
endinterface

interface bds_out_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] piece_min_x;
    logic signed [COORD_WIDTH-1:0] piece_min_y;
    logic signed [COORD_WIDTH-1:0] piece_min_z;
    logic signed [COORD_WIDTH-1:0] piece_max_x;
    logic signed [COORD_WIDTH-1:0] piece_max_y;
    logic signed [COORD_WIDTH-1:0] piece_max_z;
    logic [2:0]                    piece_kind;
    logic                          last_piece;

    modport source (
        output valid, piece_min_x, piece_min_y, piece_min_z,
               piece_max_x, piece_max_y, piece_max_z, piece_kind, last_piece,
        input  ready
    );
    modport sink (
        input  valid, piece_min_x, piece_min_y, piece_min_z,
               piece_max_x, piece_max_y, piece_max_z, piece_kind, last_piece,
        output ready
    );
endinterface

// ===== design/bds_front.sv =====
// Front of the box difference splitter: accepts a box pair, decides which
// pieces it yields and forms the clipped z and x ranges. Uses bds_pkg.
module bds_front #(
    parameter int COORD_WIDTH = 32
) (
    bds_in_if.sink                                         i_in,
    input  logic                                           i_q_ready,
    output logic                                           o_push,
    output logic [bds_pkg::NUM_KINDS-1:0]                  o_mask,
    output logic [bds_pkg::NUM_COORDS*COORD_WIDTH-1:0]     o_coords
);
    localparam int CW = COORD_WIDTH;

    logic                 w_hit;
    logic signed [CW-1:0] w_mz0, w_mz1, w_mx0, w_mx1;
    logic signed [CW-1:0] w_c [bds_pkg::NUM_COORDS];

    // A transaction is taken whenever the queue has room.
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    // Overlap test with exclusive maxima on all three axes.
    assign w_hit = (i_in.a_min_x < i_in.b_max_x) && (i_in.b_min_x < i_in.a_max_x) &&
                   (i_in.a_min_y < i_in.b_max_y) && (i_in.b_min_y < i_in.a_max_y) &&
                   (i_in.a_min_z < i_in.b_max_z) && (i_in.b_min_z < i_in.a_max_z);

    // Shared z and x ranges of the two boxes.
    assign w_mz0 = (i_in.a_min_z < i_in.b_min_z) ? i_in.b_min_z : i_in.a_min_z;
    assign w_mz1 = (i_in.b_max_z < i_in.a_max_z) ? i_in.b_max_z : i_in.a_max_z;
    assign w_mx0 = (i_in.a_min_x < i_in.b_min_x) ? i_in.b_min_x : i_in.a_min_x;
    assign w_mx1 = (i_in.b_max_x < i_in.a_max_x) ? i_in.b_max_x : i_in.a_max_x;

    // One mask bit for each piece that this pair yields.
    always_comb begin
        o_mask = '0;
        if (!w_hit) begin
            o_mask[bds_pkg::KIND_WHOLE] = 1'b1;
        end else begin
            o_mask[bds_pkg::KIND_BELOW_Z] = i_in.a_min_z < i_in.b_min_z;
            o_mask[bds_pkg::KIND_ABOVE_Z] = i_in.b_max_z < i_in.a_max_z;
            o_mask[bds_pkg::KIND_X_MIN]   = i_in.a_min_x < i_in.b_min_x;
            o_mask[bds_pkg::KIND_X_MAX]   = i_in.b_max_x < i_in.a_max_x;
            o_mask[bds_pkg::KIND_Y_MIN]   = i_in.a_min_y < i_in.b_min_y;
            o_mask[bds_pkg::KIND_Y_MAX]   = i_in.b_max_y < i_in.a_max_y;
        end
    end

    // Gather the coordinates that the back needs into their job slots.
    assign w_c[bds_pkg::J_AX0] = i_in.a_min_x;
    assign w_c[bds_pkg::J_AY0] = i_in.a_min_y;
    assign w_c[bds_pkg::J_AZ0] = i_in.a_min_z;
    assign w_c[bds_pkg::J_AX1] = i_in.a_max_x;
    assign w_c[bds_pkg::J_AY1] = i_in.a_max_y;
    assign w_c[bds_pkg::J_AZ1] = i_in.a_max_z;
    assign w_c[bds_pkg::J_BX0] = i_in.b_min_x;
    assign w_c[bds_pkg::J_BY0] = i_in.b_min_y;
    assign w_c[bds_pkg::J_BZ0] = i_in.b_min_z;
    assign w_c[bds_pkg::J_BX1] = i_in.b_max_x;
    assign w_c[bds_pkg::J_BY1] = i_in.b_max_y;
    assign w_c[bds_pkg::J_BZ1] = i_in.b_max_z;
    assign w_c[bds_pkg::J_MZ0] = w_mz0;
    assign w_c[bds_pkg::J_MZ1] = w_mz1;
    assign w_c[bds_pkg::J_MX0] = w_mx0;
    assign w_c[bds_pkg::J_MX1] = w_mx1;

    for (genvar g = 0; g < bds_pkg::NUM_COORDS; g++) begin : g_pack
        assign o_coords[g*CW +: CW] = w_c[g];
    end

endmodule

// ===== design/bds_queue.sv =====
// Short job queue between the front and the back of the box difference
// splitter. Uses bds_pkg for its depth.
module bds_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int DEPTH = bds_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic             w_push, w_pop;

    assign o_ready = r_count != CNTW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/bds_back.sv =====
// Back of the box difference splitter: walks the piece mask of one job and
// sends one piece per cycle, while the output register is free. Uses bds_pkg.
module bds_back #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_q_valid,
    input  logic [bds_pkg::NUM_KINDS-1:0]              i_q_mask,
    input  logic [bds_pkg::NUM_COORDS*COORD_WIDTH-1:0] i_q_coords,
    output logic                                       o_pop,
    bds_out_if.source                                  o_out
);
    localparam int CW = COORD_WIDTH;
    localparam int NK = bds_pkg::NUM_KINDS;

    logic [NK-1:0]                          r_mask;
    logic [bds_pkg::NUM_COORDS*CW-1:0]      r_coords;
    logic signed [CW-1:0]                   w_c [bds_pkg::NUM_COORDS];
    logic                                   r_out_valid;
    logic signed [CW-1:0]                   r_x0, r_y0, r_z0, r_x1, r_y1, r_z1;
    bds_pkg::t_piece_kind                   r_kind;
    logic                                   r_last;

    logic                                   w_out_free, w_emit;
    logic [2:0]                             w_sel;
    logic [NK-1:0]                          w_mask_after;
    logic signed [CW-1:0]                   w_x0, w_y0, w_z0, w_x1, w_y1, w_z1;

    for (genvar g = 0; g < bds_pkg::NUM_COORDS; g++) begin : g_unpack
        assign w_c[g] = r_coords[g*CW +: CW];
    end

    // Pick the lowest pending piece, which is the next one in output order.
    always_comb begin
        w_sel = '0;
        for (int i = NK - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_sel = 3'(i);
            end
        end
    end

    // Emit when a piece is pending and the output register is free; pull the
    // next job as soon as the current one has nothing left after this cycle.
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_emit       = (r_mask != '0) && w_out_free;
    assign w_mask_after = w_emit ? (r_mask & ~(NK'(1) << w_sel)) : r_mask;
    assign o_pop        = (w_mask_after == '0) && i_q_valid;

    // Corners of the selected piece.
    always_comb begin
        w_x0 = w_c[bds_pkg::J_AX0];
        w_y0 = w_c[bds_pkg::J_AY0];
        w_z0 = w_c[bds_pkg::J_AZ0];
        w_x1 = w_c[bds_pkg::J_AX1];
        w_y1 = w_c[bds_pkg::J_AY1];
        w_z1 = w_c[bds_pkg::J_AZ1];
        unique case (bds_pkg::t_piece_kind'(w_sel))
            bds_pkg::KIND_WHOLE: begin
            end
            bds_pkg::KIND_BELOW_Z: begin
                w_z1 = w_c[bds_pkg::J_BZ0];
            end
            bds_pkg::KIND_ABOVE_Z: begin
                w_z0 = w_c[bds_pkg::J_BZ1];
            end
            bds_pkg::KIND_X_MIN: begin
                w_z0 = w_c[bds_pkg::J_MZ0];
                w_x1 = w_c[bds_pkg::J_BX0];
                w_z1 = w_c[bds_pkg::J_MZ1];
            end
            bds_pkg::KIND_X_MAX: begin
                w_x0 = w_c[bds_pkg::J_BX1];
                w_z0 = w_c[bds_pkg::J_MZ0];
                w_z1 = w_c[bds_pkg::J_MZ1];
            end
            bds_pkg::KIND_Y_MIN: begin
                w_x0 = w_c[bds_pkg::J_MX0];
                w_z0 = w_c[bds_pkg::J_MZ0];
                w_x1 = w_c[bds_pkg::J_MX1];
                w_y1 = w_c[bds_pkg::J_BY0];
                w_z1 = w_c[bds_pkg::J_MZ1];
            end
            bds_pkg::KIND_Y_MAX: begin
                w_x0 = w_c[bds_pkg::J_MX0];
                w_y0 = w_c[bds_pkg::J_BY1];
                w_z0 = w_c[bds_pkg::J_MZ0];
                w_x1 = w_c[bds_pkg::J_MX1];
                w_z1 = w_c[bds_pkg::J_MZ1];
            end
            default: begin
            end
        endcase
    end

    // Control state: pending pieces and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= o_pop ? i_q_mask : w_mask_after;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job and output payload registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_coords <= i_q_coords;
        end
        if (w_emit) begin
            r_x0   <= w_x0;
            r_y0   <= w_y0;
            r_z0   <= w_z0;
            r_x1   <= w_x1;
            r_y1   <= w_y1;
            r_z1   <= w_z1;
            r_kind <= bds_pkg::t_piece_kind'(w_sel);
            r_last <= w_mask_after == '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.piece_min_x = r_x0;
    assign o_out.piece_min_y = r_y0;
    assign o_out.piece_min_z = r_z0;
    assign o_out.piece_max_x = r_x1;
    assign o_out.piece_max_y = r_y1;
    assign o_out.piece_max_z = r_z1;
    assign o_out.piece_kind  = r_kind;
    assign o_out.last_piece  = r_last;

endmodule

// ===== design/box_difference_splitter.sv =====
// Top level of the box difference splitter: front, job queue and back.
// Depends on bds_pkg, bds_channels, bds_front, bds_queue and bds_back.
//
// Takes a pair of integer boxes A and B (inclusive minima, exclusive maxima)
// and returns the pieces of A outside B, one piece per transaction on the
// output channel: A whole when the boxes do not overlap, otherwise up to six
// slabs in the order below z, above z, x-min, x-max, y-min, y-max, with the
// final piece of each pair flagged by last_piece; a pair where B covers A
// returns nothing. An input transaction can be taken every cycle while the
// two-entry job queue has room. The back sends one piece per cycle while
// the receiver takes them, and a pair that yields none still takes its turn
// in the back. An accepted pair passes the job queue and the back's job
// registers before its first piece reaches the output register.
module box_difference_splitter #(
    parameter int COORD_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bds_in_if.sink     i_in,
    bds_out_if.source  o_out
);
    localparam int CORD_BITS = bds_pkg::NUM_COORDS * COORD_WIDTH;
    localparam int JOB_W     = bds_pkg::NUM_KINDS + CORD_BITS;

    logic                          w_push, w_q_ready, w_q_valid, w_pop;
    logic [bds_pkg::NUM_KINDS-1:0] w_f_mask;
    logic [CORD_BITS-1:0]          w_f_coords;
    logic [JOB_W-1:0]              w_q_data;

    // Classify the incoming pair.
    bds_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_in     (i_in),
        .i_q_ready(w_q_ready),
        .o_push   (w_push),
        .o_mask   (w_f_mask),
        .o_coords (w_f_coords)
    );

    // Decouple classification from piece output.
    bds_queue #(
        .WIDTH(JOB_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_f_mask, w_f_coords}),
        .o_ready(w_q_ready),
        .o_valid(w_q_valid),
        .o_data (w_q_data),
        .i_pop  (w_pop)
    );

    // Emit the pieces.
    bds_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_mask  (w_q_data[JOB_W-1 -: bds_pkg::NUM_KINDS]),
        .i_q_coords(w_q_data[CORD_BITS-1:0]),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

// ===== test/box_difference_splitter_tb.sv =====
// Self-checking testbench for box_difference_splitter: box pairs go in on the input
// channel and a scoreboard class checks every piece that comes back.
// Depends on bds_pkg, bds_channels and the splitter RTL.
module box_difference_splitter_tb;

    localparam int COORD_WIDTH     = 32;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int SETTLE_CYCLES   = 8;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    // One input transaction: box A and box B, minima inclusive, maxima exclusive.
    typedef struct packed {
        t_coord ax0, ay0, az0, ax1, ay1, az1;
        t_coord bx0, by0, bz0, bx1, by1, bz1;
    } t_box_pair;

    // One output transaction.
    typedef struct packed {
        t_coord               x0, y0, z0, x1, y1, z1;
        bds_pkg::t_piece_kind kind;
        logic                 last;
    } t_piece;

    // Scoreboard: works out the pieces of each accepted pair and checks them in order.
    class piece_scoreboard;
        t_piece expected_pieces[$];
        int     errors;

        static function bit below(t_coord a, t_coord b);
            return a < b;
        endfunction

        static function t_coord higher(t_coord a, t_coord b);
            return below(a, b) ? b : a;
        endfunction

        static function t_coord lower(t_coord a, t_coord b);
            return below(b, a) ? b : a;
        endfunction

        static function t_piece slab(t_coord x0, t_coord y0, t_coord z0, t_coord x1,
                                     t_coord y1, t_coord z1, bds_pkg::t_piece_kind kind);
            t_piece s;
            s.x0   = x0;
            s.y0   = y0;
            s.z0   = z0;
            s.x1   = x1;
            s.y1   = y1;
            s.z1   = z1;
            s.kind = kind;
            s.last = 1'b0;
            return s;
        endfunction

        function int pending();
            return expected_pieces.size();
        endfunction

        // Split A by B and queue the pieces that should come out.
        function void note_pair(t_box_pair p);
            t_piece pieces[$];
            t_coord mz0, mz1, mx0, mx1;
            if (!(below(p.ax0, p.bx1) && below(p.bx0, p.ax1) &&
                  below(p.ay0, p.by1) && below(p.by0, p.ay1) &&
                  below(p.az0, p.bz1) && below(p.bz0, p.az1))) begin
                pieces.push_back(slab(p.ax0, p.ay0, p.az0, p.ax1, p.ay1, p.az1,
                                      bds_pkg::KIND_WHOLE));
            end else begin
                if (below(p.az0, p.bz0))
                    pieces.push_back(slab(p.ax0, p.ay0, p.az0, p.ax1, p.ay1, p.bz0,
                                          bds_pkg::KIND_BELOW_Z));
                if (below(p.bz1, p.az1))
                    pieces.push_back(slab(p.ax0, p.ay0, p.bz1, p.ax1, p.ay1, p.az1,
                                          bds_pkg::KIND_ABOVE_Z));
                mz0 = higher(p.az0, p.bz0);
                mz1 = lower(p.az1, p.bz1);
                if (below(p.ax0, p.bx0))
                    pieces.push_back(slab(p.ax0, p.ay0, mz0, p.bx0, p.ay1, mz1,
                                          bds_pkg::KIND_X_MIN));
                if (below(p.bx1, p.ax1))
                    pieces.push_back(slab(p.bx1, p.ay0, mz0, p.ax1, p.ay1, mz1,
                                          bds_pkg::KIND_X_MAX));
                mx0 = higher(p.ax0, p.bx0);
                mx1 = lower(p.ax1, p.bx1);
                if (below(p.ay0, p.by0))
                    pieces.push_back(slab(mx0, p.ay0, mz0, mx1, p.by0, mz1,
                                          bds_pkg::KIND_Y_MIN));
                if (below(p.by1, p.ay1))
                    pieces.push_back(slab(mx0, p.by1, mz0, mx1, p.ay1, mz1,
                                          bds_pkg::KIND_Y_MAX));
            end
            if (pieces.size() > 0)
                pieces[pieces.size()-1].last = 1'b1;
            foreach (pieces[i])
                expected_pieces.push_back(pieces[i]);
        endfunction

        function void compare(string field, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        // Check one output transaction against the oldest expected piece.
        function void check_piece(t_piece got);
            t_piece want;
            if (expected_pieces.size() == 0) begin
                errors++;
                $display("%0t: piece kind %0d arrived, expected none", $time, got.kind);
                return;
            end
            want = expected_pieces.pop_front();
            compare("piece_min_x", want.x0, got.x0);
            compare("piece_min_y", want.y0, got.y0);
            compare("piece_min_z", want.z0, got.z0);
            compare("piece_max_x", want.x1, got.x1);
            compare("piece_max_y", want.y1, got.y1);
            compare("piece_max_z", want.z1, got.z1);
            compare("piece_kind", want.kind, got.kind);
            compare("last_piece", want.last, got.last);
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    int unsigned     cycle_count = 0;
    int              send_idle_pct;
    int              recv_idle_pct;
    piece_scoreboard sb;

    bds_in_if  #(.COORD_WIDTH(COORD_WIDTH)) in_ch ();
    bds_out_if #(.COORD_WIDTH(COORD_WIDTH)) out_ch ();

    box_difference_splitter #(.COORD_WIDTH(COORD_WIDTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock with a period of 10.
    always #5 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver back-pressure, changed at the falling edge.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output monitor: every accepted piece goes to the scoreboard.
    always @(posedge i_clk) begin
        t_piece got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.x0   = out_ch.piece_min_x;
            got.y0   = out_ch.piece_min_y;
            got.z0   = out_ch.piece_min_z;
            got.x1   = out_ch.piece_max_x;
            got.y1   = out_ch.piece_max_y;
            got.z1   = out_ch.piece_max_z;
            got.kind = bds_pkg::t_piece_kind'(out_ch.piece_kind);
            got.last = out_ch.last_piece;
            sb.check_piece(got);
        end
    end

    function automatic t_box_pair cubes(t_coord a_lo, t_coord a_hi, t_coord b_lo, t_coord b_hi);
        t_box_pair p;
        p.ax0 = a_lo;
        p.ay0 = a_lo;
        p.az0 = a_lo;
        p.ax1 = a_hi;
        p.ay1 = a_hi;
        p.az1 = a_hi;
        p.bx0 = b_lo;
        p.by0 = b_lo;
        p.bz0 = b_lo;
        p.bx1 = b_hi;
        p.by1 = b_hi;
        p.bz1 = b_hi;
        return p;
    endfunction

    // A fully random coordinate, or one from the edges of the range.
    function automatic t_coord any_coord(bit extreme);
        if (!extreme)
            return t_coord'($urandom);
        case ($urandom_range(5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            default: return t_coord'($urandom);
        endcase
    endfunction

    // A short interval near base; a ragged one may come out empty or inverted.
    function automatic void window(input t_coord base, input bit ragged,
                                   output t_coord lo, output t_coord hi);
        lo = base + t_coord'($urandom_range(12));
        if (ragged)
            hi = lo + t_coord'($urandom_range(12)) - t_coord'($urandom_range(4));
        else
            hi = lo + t_coord'($urandom_range(12, 1));
    endfunction

    // Mostly nearby, well-formed boxes that often overlap; the rest free or extreme values.
    function automatic t_box_pair random_pair();
        t_box_pair p;
        t_coord    base;
        int        mode;
        bit        extreme;
        bit        ragged;
        mode = $urandom_range(99);
        if (mode < 25) begin
            extreme = (mode < 10);
            p.ax0 = any_coord(extreme);
            p.ay0 = any_coord(extreme);
            p.az0 = any_coord(extreme);
            p.ax1 = any_coord(extreme);
            p.ay1 = any_coord(extreme);
            p.az1 = any_coord(extreme);
            p.bx0 = any_coord(extreme);
            p.by0 = any_coord(extreme);
            p.bz0 = any_coord(extreme);
            p.bx1 = any_coord(extreme);
            p.by1 = any_coord(extreme);
            p.bz1 = any_coord(extreme);
        end else begin
            ragged = (mode >= 85);
            case ($urandom_range(5))
                0:       base = t_coord'($urandom);
                1:       base = COORD_MAX - 30;
                2:       base = COORD_MIN;
                default: base = t_coord'($urandom_range(40)) - 20;
            endcase
            window(base, ragged, p.ax0, p.ax1);
            window(base, ragged, p.ay0, p.ay1);
            window(base, ragged, p.az0, p.az1);
            window(base, ragged, p.bx0, p.bx1);
            window(base, ragged, p.by0, p.by1);
            window(base, ragged, p.bz0, p.bz1);
            // Stretch B over A on some axes so that lone slabs and full covers occur.
            if ($urandom_range(2) == 0) begin
                p.bx0 = p.ax0 - t_coord'($urandom_range(2));
                p.bx1 = p.ax1 + t_coord'($urandom_range(2));
            end
            if ($urandom_range(2) == 0) begin
                p.by0 = p.ay0 - t_coord'($urandom_range(2));
                p.by1 = p.ay1 + t_coord'($urandom_range(2));
            end
            if ($urandom_range(2) == 0) begin
                p.bz0 = p.az0 - t_coord'($urandom_range(2));
                p.bz1 = p.az1 + t_coord'($urandom_range(2));
            end
        end
        return p;
    endfunction

    // Offer one pair at the falling edge and hold it until the block takes it.
    task automatic send_pair(input t_box_pair p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.a_min_x <= p.ax0;
        in_ch.a_min_y <= p.ay0;
        in_ch.a_min_z <= p.az0;
        in_ch.a_max_x <= p.ax1;
        in_ch.a_max_y <= p.ay1;
        in_ch.a_max_z <= p.az1;
        in_ch.b_min_x <= p.bx0;
        in_ch.b_min_y <= p.by0;
        in_ch.b_min_z <= p.bz0;
        in_ch.b_max_x <= p.bx1;
        in_ch.b_max_y <= p.by1;
        in_ch.b_max_z <= p.bz1;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        sb.note_pair(p);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    // Stop sending and let every expected piece come out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Main sequence: reset, directed pairs, then three random phases.
    initial begin
        t_box_pair p;
        sb            = new();
        send_idle_pct = 27;
        recv_idle_pct = 69;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.a_min_x <= '0;
        in_ch.a_min_y <= '0;
        in_ch.a_min_z <= '0;
        in_ch.a_max_x <= '0;
        in_ch.a_max_y <= '0;
        in_ch.a_max_z <= '0;
        in_ch.b_min_x <= '0;
        in_ch.b_min_y <= '0;
        in_ch.b_min_z <= '0;
        in_ch.b_max_x <= '0;
        in_ch.b_max_y <= '0;
        in_ch.b_max_z <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Disjoint in x, and touching in z: A passes whole.
        p = cubes(0, 10, 0, 10);
        p.bx0 = 20;
        p.bx1 = 30;
        send_pair(p);
        p = cubes(0, 10, 0, 10);
        p.bz0 = 10;
        p.bz1 = 20;
        send_pair(p);
        // B strictly inside A gives all six slabs; covers give nothing.
        send_pair(cubes(0, 10, 2, 5));
        send_pair(cubes(2, 5, 0, 10));
        send_pair(cubes(0, 10, 0, 10));
        // Each slab kind on its own.
        p = cubes(0, 10, -5, 15);
        p.bz0 = 5;
        p.bz1 = 20;
        send_pair(p);
        p = cubes(0, 10, -5, 15);
        p.bz1 = 5;
        send_pair(p);
        p = cubes(0, 10, -5, 15);
        p.bx0 = 5;
        send_pair(p);
        p = cubes(0, 10, -5, 15);
        p.bx1 = 5;
        send_pair(p);
        p = cubes(0, 10, -5, 15);
        p.by0 = 5;
        send_pair(p);
        p = cubes(0, 10, -5, 15);
        p.by1 = 5;
        send_pair(p);
        // Edges of the coordinate range.
        send_pair(cubes(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_pair(cubes(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_pair(cubes(COORD_MIN, COORD_MAX, -1, 1));
        send_pair(cubes(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_pair(cubes(COORD_MIN, 0, -1, COORD_MAX));
        // Inverted and empty boxes that still pass the overlap test.
        p = cubes(0, 10, 2, 5);
        p.ax0 = 4;
        p.ax1 = 3;
        send_pair(p);
        p = cubes(0, 10, 2, 5);
        p.ay0 = 3;
        p.ay1 = 3;
        send_pair(p);
        send_pair(cubes(0, 10, 3, 3));
        // Around zero, and alternating bit patterns.
        send_pair(cubes(-1, 1, 0, 1));
        send_pair(cubes(t_coord'(32'hAAAA_AAAA), t_coord'(32'h5555_5555), 0, 1));
        send_pair(cubes(t_coord'(32'h5555_5555), t_coord'(32'hAAAA_AAAA),
                        t_coord'(32'hAAAA_AAAA), t_coord'(32'h5555_5555)));

        // Slow receiver, then a full pause of the sender.
        send_random(ITEMS_PER_PHASE);
        drain();

        // Slow sender.
        send_idle_pct = 69;
        recv_idle_pct = 27;
        send_random(ITEMS_PER_PHASE);

        // Both sides at full rate.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(ITEMS_PER_PHASE);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
design/bds_pkg.sv
design/bds_channels.sv
design/bds_front.sv
design/bds_queue.sv
design/bds_back.sv
design/box_difference_splitter.sv
test/box_difference_splitter_tb.sv
